// ----- hw/rtl/combined_lcg_shuffle_rng_core_macros.svh -----
// Assertion macros for the checker file clsr_checker.sv.
`ifndef COMBINED_LCG_SHUFFLE_RNG_CORE_MACROS_SVH
`define COMBINED_LCG_SHUFFLE_RNG_CORE_MACROS_SVH

// checked only outside reset
`define CLSR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define CLSR_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/clsr_pkg.sv -----
`default_nettype none

package clsr_pkg;

   localparam int unsigned VAL_W      = 31;
   localparam int unsigned TABLE_SIZE = 64;
   localparam int unsigned IDX_W      = 6;
   localparam int unsigned MULT_W     = 16;
   localparam int unsigned PROD_W     = VAL_W + MULT_W;

   localparam logic [MULT_W-1:0] MULT_ONE = 16'd40014;
   localparam logic [MULT_W-1:0] MULT_TWO = 16'd40692;
   localparam logic [VAL_W-1:0]  MOD_ONE  = 31'd2147483563;
   localparam logic [VAL_W-1:0]  MOD_TWO  = 31'd2147483399;
   // 2^31 minus each modulus
   localparam logic [7:0]        FOLD_ONE = 8'd85;
   localparam logic [7:0]        FOLD_TWO = 8'd249;
   localparam logic [VAL_W-1:0]  SEED_RESET = 31'd42;

   typedef struct packed {
      logic load;
      logic advance;
   } gen_ctrl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT_MUL,
      ST_INIT_RED,
      ST_INIT_WR,
      ST_DRAW_RED,
      ST_DRAW_WR,
      ST_HOLD
   } state_type;

   // p mod (2^31 - c): fold the high part down once, then one subtract
   function automatic logic [VAL_W-1:0] fold_mod(input logic [PROD_W-1:0] prod,
                                                 input logic [7:0]        c,
                                                 input logic [VAL_W-1:0]  m);
      logic [31:0] hi_c;
      logic [31:0] sum;
      hi_c = {16'b0, prod[PROD_W-1:VAL_W]} * {24'b0, c};
      sum  = {1'b0, prod[VAL_W-1:0]} + hi_c;
      if (sum >= {1'b0, m}) begin
         sum = sum - {1'b0, m};
      end
      return sum[VAL_W-1:0];
   endfunction

   // floor(v * 64 / m1) for v below m1: take the top bits, then correct by one
   function automatic logic [IDX_W-1:0] slot_of(input logic [VAL_W-1:0] v);
      logic [IDX_W-1:0] k;
      logic [12:0]      corr;
      logic [31:0]      sum;
      k    = v[VAL_W-1 -: IDX_W];
      corr = ({7'b0, k} + 13'd1) * {5'b0, FOLD_ONE};
      sum  = {1'b0, v[VAL_W-IDX_W-1:0], 6'b0} + {19'b0, corr};
      if (sum[31] && (k != IDX_W'(TABLE_SIZE - 1))) begin
         return k + 6'd1;
      end
      return k;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/clsr_gen_pair.sv -----
`default_nettype none

module clsr_gen_pair (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire clsr_pkg::gen_ctrl_type     ctrl,
   input  wire logic [clsr_pkg::VAL_W-1:0] seed,
   output logic      [clsr_pkg::VAL_W-1:0] gen_diff
);

   logic [clsr_pkg::VAL_W-1:0]  gen_one_ff, gen_one_in;
   logic [clsr_pkg::VAL_W-1:0]  gen_two_ff, gen_two_in;
   logic [clsr_pkg::PROD_W-1:0] prod_one_ff, prod_two_ff;

   // products track the generators every cycle; registered, so valid in the cycle after a change
   always_ff @(posedge clock) begin
      prod_one_ff <= {16'b0, gen_one_ff} * {31'b0, clsr_pkg::MULT_ONE};
      prod_two_ff <= {16'b0, gen_two_ff} * {31'b0, clsr_pkg::MULT_TWO};
   end

   always_comb begin
      gen_one_in = gen_one_ff;
      gen_two_in = gen_two_ff;
      if (ctrl.load) begin
         gen_one_in = seed;
         gen_two_in = seed;
      end else if (ctrl.advance) begin
         gen_one_in = clsr_pkg::fold_mod(prod_one_ff, clsr_pkg::FOLD_ONE, clsr_pkg::MOD_ONE);
         gen_two_in = clsr_pkg::fold_mod(prod_two_ff, clsr_pkg::FOLD_TWO, clsr_pkg::MOD_TWO);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_one_ff <= '0;
         gen_two_ff <= '0;
      end else begin
         gen_one_ff <= gen_one_in;
         gen_two_ff <= gen_two_in;
      end
   end

   // wrap the difference into 0 .. m1-1; modulo 2^31 arithmetic lands exactly
   always_comb begin
      if (gen_one_ff >= gen_two_ff) begin
         gen_diff = gen_one_ff - gen_two_ff;
      end else begin
         gen_diff = gen_one_ff - gen_two_ff + clsr_pkg::MOD_ONE;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/combined_lcg_shuffle_rng_core.sv -----
// Channel   Direction  Ports                              Word
// req       in         req_valid / req_ready              req_reseed
// rsp       out        rsp_valid / rsp_ready              rsp_value
// csr       in         csr_wr_en                          csr_wr_data (seed)
//
// A draw reads the shuffle memory in ST_DRAW_RED, then writes back and loads the output
// register in ST_DRAW_WR (or in ST_HOLD once rsp is free) and returns to ST_IDLE for the next
// request; each draw is one read of the shuffle memory and one write-back. Initialisation
// runs ST_INIT_MUL for the multipliers to settle on the seed, then 64 fills (fold, write).
// Reset: idle, seed 42, initialisation pending; the shuffle memory is not cleared.
// A stalled rsp holds its word; one more draw runs meanwhile, then holds req off.
`default_nettype none

module combined_lcg_shuffle_rng_core (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic                       req_reseed,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic      [clsr_pkg::VAL_W-1:0] rsp_value,
   input  wire logic                       csr_wr_en,
   input  wire logic [clsr_pkg::VAL_W-1:0] csr_wr_data
);

   clsr_pkg::state_type         state_ff, state_in;
   clsr_pkg::gen_ctrl_type      gen_ctrl;
   logic [clsr_pkg::VAL_W-1:0]  seed_ff;
   logic                        init_pending_ff;
   logic [clsr_pkg::VAL_W-1:0]  last_value_ff;
   logic [clsr_pkg::IDX_W-1:0]  slot_ff;
   logic [clsr_pkg::IDX_W-1:0]  cnt_ff, cnt_in;
   logic [clsr_pkg::VAL_W-1:0]  rdata_ff;
   logic                        rsp_valid_ff;
   logic [clsr_pkg::VAL_W-1:0]  rsp_value_ff;
   logic [clsr_pkg::VAL_W-1:0]  gen_diff;
   logic [clsr_pkg::VAL_W-1:0]  table_mem [clsr_pkg::TABLE_SIZE];

   logic                        rsp_free;
   logic                        start_init;
   logic                        wr_en;
   logic [clsr_pkg::IDX_W-1:0]  wr_addr;
   logic                        rd_en;
   logic [clsr_pkg::IDX_W-1:0]  rd_addr;
   logic                        lv_load;
   logic                        rsp_load;
   logic [clsr_pkg::VAL_W-1:0]  rsp_src;

   clsr_gen_pair u_gen_pair (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (gen_ctrl),
      .seed     (seed_ff),
      .gen_diff (gen_diff)
   );

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign rd_addr   = clsr_pkg::slot_of(last_value_ff);
   assign req_ready = (state_ff == clsr_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

   always_comb begin
      state_in         = state_ff;
      gen_ctrl         = '0;
      cnt_in           = cnt_ff;
      start_init       = 1'b0;
      wr_en            = 1'b0;
      wr_addr          = cnt_ff;
      rd_en            = 1'b0;
      lv_load          = 1'b0;
      rsp_load         = 1'b0;
      rsp_src          = last_value_ff;
      case (state_ff)
         clsr_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (init_pending_ff || req_reseed) begin
                  gen_ctrl.load = 1'b1;
                  start_init    = 1'b1;
                  cnt_in        = '0;
                  state_in      = clsr_pkg::ST_INIT_MUL;
               end else begin
                  state_in = clsr_pkg::ST_DRAW_RED;
               end
            end
         end
         clsr_pkg::ST_INIT_MUL: begin
            state_in = clsr_pkg::ST_INIT_RED;
         end
         clsr_pkg::ST_INIT_RED: begin
            gen_ctrl.advance = 1'b1;
            state_in         = clsr_pkg::ST_INIT_WR;
         end
         clsr_pkg::ST_INIT_WR: begin
            wr_en   = 1'b1;
            wr_addr = cnt_ff;
            cnt_in  = cnt_ff + 6'd1;
            if (cnt_ff == clsr_pkg::IDX_W'(clsr_pkg::TABLE_SIZE - 1)) begin
               state_in = clsr_pkg::ST_DRAW_RED;
            end else begin
               state_in = clsr_pkg::ST_INIT_RED;
            end
         end
         clsr_pkg::ST_DRAW_RED: begin
            gen_ctrl.advance = 1'b1;
            rd_en            = 1'b1;
            state_in         = clsr_pkg::ST_DRAW_WR;
         end
         clsr_pkg::ST_DRAW_WR: begin
            wr_en   = 1'b1;
            wr_addr = slot_ff;
            lv_load = 1'b1;
            rsp_src = rdata_ff;
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = clsr_pkg::ST_IDLE;
            end else begin
               state_in = clsr_pkg::ST_HOLD;
            end
         end
         clsr_pkg::ST_HOLD: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = clsr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = clsr_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= clsr_pkg::ST_IDLE;
         seed_ff         <= clsr_pkg::SEED_RESET;
         init_pending_ff <= 1'b1;
         last_value_ff   <= '0;
         cnt_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (csr_wr_en) begin
            seed_ff         <= csr_wr_data;
            init_pending_ff <= 1'b1;
         end else if (start_init) begin
            init_pending_ff <= 1'b0;
         end
         if (lv_load) begin
            last_value_ff <= rdata_ff;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_value_ff <= rsp_src;
      end
      if (rd_en) begin
         slot_ff <= rd_addr;
      end
   end

   // shuffle table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= gen_diff;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= table_mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/clsr_checker.sv -----
`default_nettype none

`include "combined_lcg_shuffle_rng_core_macros.svh"

module clsr_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_valid,
   input wire logic                       req_ready,
   input wire logic                       req_reseed,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_ready,
   input wire logic [clsr_pkg::VAL_W-1:0] rsp_value,
   input wire logic                       csr_wr_en,
   input wire logic [clsr_pkg::VAL_W-1:0] csr_wr_data
);

   logic unused_ok;
   assign unused_ok = req_reseed ^ csr_wr_en ^ (^csr_wr_data);

   // hold a stalled word
   `CLSR_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value), "rsp word changed while stalled")

   // every word is a residue of the first modulus
   `CLSR_ASSERT(a_rsp_range, clock, reset, rsp_valid |-> rsp_value < clsr_pkg::MOD_ONE, "rsp_value out of range")

   // one draw at a time
   `CLSR_ASSERT(a_req_busy, clock, reset, req_valid && req_ready |=> !req_ready, "req taken twice in a row")

   // reset empties the output register
   `CLSR_ASSERT_ALWAYS(a_rsp_reset, clock, reset |=> !rsp_valid, "rsp_valid after reset")

endmodule

bind combined_lcg_shuffle_rng_core clsr_checker u_clsr_checker (.*);

`default_nettype wire
